>>> design/fixed_point_matrix_rotator_defines.svh
// Assertion macros for the fixed-point matrix rotator.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef FIXED_POINT_MATRIX_ROTATOR_DEFINES_SVH
`define FIXED_POINT_MATRIX_ROTATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define FPMR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FPMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FPMR_ASSERT_SAME(label, ante, cons, msg)
`define FPMR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> design/fpmr_pkg.sv
// Shared types, codes and helpers for the fixed-point matrix rotator.
// No dependencies.
package fpmr_pkg;

  localparam int ENTRY_W   = 16;
  localparam int VEC_W     = ENTRY_W + 1;  // room for the negated sine
  localparam int FRAC_BITS = 12;
  localparam int ACC_W     = 44;
  localparam int RES_W     = ACC_W - FRAC_BITS;
  localparam int N_ROWS    = 3;
  localparam int N_ENTRIES = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ROTATE = 2'd1;
  localparam logic [1:0] REQ_MULT   = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [1:0] AXIS_Y = 2'd0;
  localparam logic [1:0] AXIS_X = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] MODE_RAW   = 2'd1;
  localparam logic [1:0] MODE_TRANS = 2'd2;

  localparam logic [2:0] WORD_LAST = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_Z = 2'd2;

  localparam logic signed [RES_W-1:0] SAT_MIN = -32'sd32768;
  localparam logic signed [RES_W-1:0] SAT_MAX = 32'sd32767;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [2:0]                word_index;
    logic [31:0]               word_data;
    logic [1:0]                axis;
    logic signed [ENTRY_W-1:0] sine;
    logic signed [ENTRY_W-1:0] cosine;
    logic signed [ENTRY_W-1:0] vec_x;
    logic signed [ENTRY_W-1:0] vec_y;
    logic signed [ENTRY_W-1:0] vec_z;
    logic [1:0]                mult_mode;
  } req_t;

  typedef struct packed {
    logic signed [RES_W-1:0] out_x;
    logic signed [RES_W-1:0] out_y;
    logic signed [RES_W-1:0] out_z;
    logic [31:0]             read_word;
  } res_t;

  function automatic logic signed [ENTRY_W-1:0] sat16(input logic signed [RES_W-1:0] v);
    logic signed [ENTRY_W-1:0] r;
    if (v < SAT_MIN) begin
      r = SAT_MIN[ENTRY_W-1:0];
    end else if (v > SAT_MAX) begin
      r = SAT_MAX[ENTRY_W-1:0];
    end else begin
      r = v[ENTRY_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/fixed_point_matrix_rotator.sv
// Fixed-point 3x3 matrix rotator: takes one request per clock while in_stall is low and
// returns one result beat per request. A taken request is held in the input register,
// and its beat is then registered in the result register and held on the out_ ports
// until it is taken. Rotations and matrix-vector multiplies finish in one pass through
// six 16x17 row dot units, and loads and reads use the matrix registers directly, so a
// request sees every matrix change made by the one before it.
// The result register lets a new request enter while a finished beat waits on out_stall.
// Translation registers are written through the cfg port (index 0..2 for x, y, z).
`include "fixed_point_matrix_rotator_defines.svh"

module fixed_point_matrix_rotator import fpmr_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [2:0]                  in_word_index,
  input  logic [31:0]                 in_word_data,
  input  logic [1:0]                  in_axis,
  input  logic signed [ENTRY_W-1:0]   in_sine,
  input  logic signed [ENTRY_W-1:0]   in_cosine,
  input  logic signed [ENTRY_W-1:0]   in_vec_x,
  input  logic signed [ENTRY_W-1:0]   in_vec_y,
  input  logic signed [ENTRY_W-1:0]   in_vec_z,
  input  logic [1:0]                  in_mult_mode,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [RES_W-1:0]     out_x,
  output logic signed [RES_W-1:0]     out_y,
  output logic signed [RES_W-1:0]     out_z,
  output logic [31:0]                 out_read_word,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                 cfg_data
);

  req_t                    s1_req_r;
  logic                    s1_valid_r;
  logic                    s1_valid_nxt;
  logic                    s1_adv;
  logic                    in_accept;
  res_t                    res;
  res_t                    res_r;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [RES_W-1:0] trans_x_r;
  logic signed [RES_W-1:0] trans_y_r;
  logic signed [RES_W-1:0] trans_z_r;

  // Advance stage 1 when the result register is empty or being drained
  assign s1_adv        = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && out_valid_r && out_stall;
  assign in_accept     = in_valid && !in_stall;
  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r.req_type   <= in_req_type;
      s1_req_r.word_index <= in_word_index;
      s1_req_r.word_data  <= in_word_data;
      s1_req_r.axis       <= in_axis;
      s1_req_r.sine       <= in_sine;
      s1_req_r.cosine     <= in_cosine;
      s1_req_r.vec_x      <= in_vec_x;
      s1_req_r.vec_y      <= in_vec_y;
      s1_req_r.vec_z      <= in_vec_z;
      s1_req_r.mult_mode  <= in_mult_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res;
    end
  end

  // Translation registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_x_r <= '0;
      trans_y_r <= '0;
      trans_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRANS_X: trans_x_r <= cfg_data;
        CFG_TRANS_Y: trans_y_r <= cfg_data;
        CFG_TRANS_Z: trans_z_r <= cfg_data;
        default:     trans_x_r <= trans_x_r;
      endcase
    end
  end

  fpmr_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (s1_req_r),
    .commit  (s1_adv),
    .trans_x (trans_x_r),
    .trans_y (trans_y_r),
    .trans_z (trans_z_r),
    .res     (res)
  );

  assign out_valid     = out_valid_r;
  assign out_x         = res_r.out_x;
  assign out_y         = res_r.out_y;
  assign out_z         = res_r.out_z;
  assign out_read_word = res_r.read_word;

  `FPMR_ASSERT_SAME(a_stall_only_when_full, in_stall, s1_valid_r && out_valid_r, "stall without full pipe")
  `FPMR_ASSERT_NEXT(a_commit_fills_output, s1_adv, out_valid_r, "committed request lost its beat")
  `FPMR_ASSERT_SAME(a_read_beat_clean, out_valid_r && (out_read_word != 32'd0), (out_x == '0) && (out_y == '0) && (out_z == '0), "read beat carries product data")

endmodule

>>> design/fpmr_dot.sv
// One matrix row times a three-element vector, 44-bit wrapping accumulate, >> 12.
// Depends on fpmr_pkg.
module fpmr_dot import fpmr_pkg::*; (
  input  logic signed [ENTRY_W-1:0] m_a,
  input  logic signed [ENTRY_W-1:0] m_b,
  input  logic signed [ENTRY_W-1:0] m_c,
  input  logic signed [VEC_W-1:0]   v_a,
  input  logic signed [VEC_W-1:0]   v_b,
  input  logic signed [VEC_W-1:0]   v_c,
  input  logic signed [ACC_W-1:0]   acc_init,
  output logic signed [RES_W-1:0]   dot_q
);

  logic signed [ENTRY_W+VEC_W-1:0] p_a;
  logic signed [ENTRY_W+VEC_W-1:0] p_b;
  logic signed [ENTRY_W+VEC_W-1:0] p_c;
  logic signed [ACC_W-1:0]         sum;

  assign p_a = m_a * v_a;
  assign p_b = m_b * v_b;
  assign p_c = m_c * v_c;

  // modular sum equals wrapping after every add
  assign sum   = acc_init + ACC_W'(p_a) + ACC_W'(p_b) + ACC_W'(p_c);
  assign dot_q = sum[ACC_W-1:FRAC_BITS];

endmodule

>>> design/fpmr_engine.sv
// Matrix storage, six row dot units and the result/update logic.
// Depends on fpmr_pkg and fpmr_dot.
module fpmr_engine import fpmr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  req_t                    req,
  input  logic                    commit,
  input  logic signed [RES_W-1:0] trans_x,
  input  logic signed [RES_W-1:0] trans_y,
  input  logic signed [RES_W-1:0] trans_z,
  output res_t                    res
);

  logic signed [ENTRY_W-1:0] mat_r   [N_ENTRIES];
  logic signed [ENTRY_W-1:0] mat_nxt [N_ENTRIES];

  logic signed [VEC_W-1:0]   va [N_ROWS];
  logic signed [VEC_W-1:0]   vb [N_ROWS];
  logic signed [ACC_W-1:0]   init_a [N_ROWS];
  logic signed [RES_W-1:0]   dot_a [N_ROWS];
  logic signed [RES_W-1:0]   dot_b [N_ROWS];
  logic signed [RES_W-1:0]   trans [N_ROWS];
  logic [1:0]                col_a;
  logic [1:0]                col_b;
  logic                      rot_ok;
  logic signed [VEC_W-1:0]   s17;
  logic signed [VEC_W-1:0]   c17;

  assign s17 = VEC_W'(req.sine);
  assign c17 = VEC_W'(req.cosine);
  assign trans[0] = trans_x;
  assign trans[1] = trans_y;
  assign trans[2] = trans_z;

  // Operand steering: rotate feeds both unit banks, multiply only bank a
  always_comb begin
    for (int r = 0; r < N_ROWS; r++) begin
      va[r]     = '0;
      vb[r]     = '0;
      init_a[r] = '0;
    end
    col_a  = 2'd0;
    col_b  = 2'd0;
    rot_ok = 1'b0;
    case (req.req_type)
      REQ_ROTATE: begin
        case (req.axis)
          AXIS_Y: begin
            va[0] = c17;  va[2] = s17;
            vb[0] = -s17; vb[2] = c17;
            col_a = 2'd0; col_b = 2'd2; rot_ok = 1'b1;
          end
          AXIS_X: begin
            va[1] = c17;  va[2] = s17;
            vb[1] = -s17; vb[2] = c17;
            col_a = 2'd1; col_b = 2'd2; rot_ok = 1'b1;
          end
          AXIS_Z: begin
            va[0] = c17;  va[1] = s17;
            vb[0] = -s17; vb[1] = c17;
            col_a = 2'd0; col_b = 2'd1; rot_ok = 1'b1;
          end
          default: rot_ok = 1'b0;
        endcase
      end
      REQ_MULT: begin
        va[0] = VEC_W'(req.vec_x);
        va[1] = VEC_W'(req.vec_y);
        va[2] = VEC_W'(req.vec_z);
        if (req.mult_mode == MODE_TRANS) begin
          for (int r = 0; r < N_ROWS; r++) begin
            init_a[r] = {trans[r], {FRAC_BITS{1'b0}}};
          end
        end
      end
      default: rot_ok = 1'b0;
    endcase
  end

  for (genvar r = 0; r < N_ROWS; r++) begin : g_row
    fpmr_dot u_dot_a (
      .m_a      (mat_r[3*r]),
      .m_b      (mat_r[3*r+1]),
      .m_c      (mat_r[3*r+2]),
      .v_a      (va[0]),
      .v_b      (va[1]),
      .v_c      (va[2]),
      .acc_init (init_a[r]),
      .dot_q    (dot_a[r])
    );
    fpmr_dot u_dot_b (
      .m_a      (mat_r[3*r]),
      .m_b      (mat_r[3*r+1]),
      .m_c      (mat_r[3*r+2]),
      .v_a      (vb[0]),
      .v_b      (vb[1]),
      .v_c      (vb[2]),
      .acc_init ('0),
      .dot_q    (dot_b[r])
    );
  end

  // Matrix update
  always_comb begin
    for (int i = 0; i < N_ENTRIES; i++) begin
      mat_nxt[i] = mat_r[i];
    end
    case (req.req_type)
      REQ_LOAD: begin
        for (int k = 0; k < 4; k++) begin
          if (req.word_index == 3'(k)) begin
            mat_nxt[2*k]   = req.word_data[15:0];
            mat_nxt[2*k+1] = req.word_data[31:16];
          end
        end
        if (req.word_index == WORD_LAST) begin
          mat_nxt[8] = req.word_data[15:0];
        end
      end
      REQ_ROTATE: begin
        if (rot_ok) begin
          for (int r = 0; r < N_ROWS; r++) begin
            for (int c = 0; c < 3; c++) begin
              if (col_a == 2'(c)) begin
                mat_nxt[3*r+c] = sat16(dot_a[r]);
              end else if (col_b == 2'(c)) begin
                mat_nxt[3*r+c] = sat16(dot_b[r]);
              end
            end
          end
        end
      end
      default: mat_nxt[0] = mat_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        mat_r[i] <= '0;
      end
    end else if (commit) begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        mat_r[i] <= mat_nxt[i];
      end
    end
  end

  // Result beat
  always_comb begin
    res = '0;
    case (req.req_type)
      REQ_MULT: begin
        if (req.mult_mode == MODE_RAW) begin
          res.out_x = dot_a[0];
          res.out_y = dot_a[1];
          res.out_z = dot_a[2];
        end else begin
          res.out_x = RES_W'(sat16(dot_a[0]));
          res.out_y = RES_W'(sat16(dot_a[1]));
          res.out_z = RES_W'(sat16(dot_a[2]));
        end
      end
      REQ_READ: begin
        for (int k = 0; k < 4; k++) begin
          if (req.word_index == 3'(k)) begin
            res.read_word = {mat_r[2*k+1], mat_r[2*k]};
          end
        end
        if (req.word_index == WORD_LAST) begin
          res.read_word = 32'(mat_r[8]);
        end
      end
      default: res = '0;
    endcase
  end

endmodule

>>> sim/fixed_point_matrix_rotator_tb.sv
// Self-checking bench for the fixed-point matrix rotator: loads, reads, rotations and
// matrix-vector multiplies against an in-bench predictor, with random gaps on both sides.
// Depends on fpmr_pkg and the fixed_point_matrix_rotator RTL.
module fixed_point_matrix_rotator_tb;
  import fpmr_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int REPORT_MAX = 10;
  localparam int PHASE_ITEMS = 138;
  localparam logic [1:0] MODE_SAT   = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] AXIS_NONE  = 2'd3;

  logic clk;
  logic rst_n;

  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                in_req_type;
  logic [2:0]                in_word_index;
  logic [31:0]               in_word_data;
  logic [1:0]                in_axis;
  logic signed [ENTRY_W-1:0] in_sine;
  logic signed [ENTRY_W-1:0] in_cosine;
  logic signed [ENTRY_W-1:0] in_vec_x;
  logic signed [ENTRY_W-1:0] in_vec_y;
  logic signed [ENTRY_W-1:0] in_vec_z;
  logic [1:0]                in_mult_mode;

  logic                      out_valid;
  logic                      out_stall;
  logic signed [RES_W-1:0]   out_x;
  logic signed [RES_W-1:0]   out_y;
  logic signed [RES_W-1:0]   out_z;
  logic [31:0]               out_read_word;

  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [31:0]               cfg_data;

  fixed_point_matrix_rotator u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_word_index (in_word_index),
    .in_word_data  (in_word_data),
    .in_axis       (in_axis),
    .in_sine       (in_sine),
    .in_cosine     (in_cosine),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .in_mult_mode  (in_mult_mode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_read_word (out_read_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor state: matrix row-major, translation per row
  logic signed [15:0] mat_q [9];
  logic signed [31:0] trans_q [3];
  res_t awaited [$];
  int mismatches;
  int idle_cycles;
  bit in_burst;
  bit out_burst;

  function automatic longint wrap44(input longint v);
    logic signed [43:0] t;
    t = v[43:0];
    return longint'(t);
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Dot product of one matrix row, accumulator wrapped to 44 bits after every add
  function automatic logic signed [31:0] row_product(input int row, input int v0,
                                                     input int v1, input int v2,
                                                     input logic signed [31:0] offset);
    longint acc;
    acc = longint'(offset) * 4096;
    acc = wrap44(acc + longint'(mat_q[row*3]) * longint'(v0));
    acc = wrap44(acc + longint'(mat_q[row*3+1]) * longint'(v1));
    acc = wrap44(acc + longint'(mat_q[row*3+2]) * longint'(v2));
    acc = acc >>> 12;
    return acc[31:0];
  endfunction

  function automatic void spin_matrix(input logic [1:0] ax, input int s, input int c);
    int ca, cb, row;
    int va [3];
    int vb [3];
    logic signed [15:0] na [3];
    logic signed [15:0] nb [3];
    case (ax)
      AXIS_Y: begin
        va = '{c, 0, s}; vb = '{-s, 0, c}; ca = 0; cb = 2;
      end
      AXIS_X: begin
        va = '{0, c, s}; vb = '{0, -s, c}; ca = 1; cb = 2;
      end
      AXIS_Z: begin
        va = '{c, s, 0}; vb = '{-s, c, 0}; ca = 0; cb = 1;
      end
      default: return;
    endcase
    // both new columns come from the old matrix
    for (row = 0; row < 3; row++) begin
      na[row] = clamp16(row_product(row, va[0], va[1], va[2], '0));
      nb[row] = clamp16(row_product(row, vb[0], vb[1], vb[2], '0));
    end
    for (row = 0; row < 3; row++) begin
      mat_q[row*3+ca] = na[row];
      mat_q[row*3+cb] = nb[row];
    end
  endfunction

  function automatic res_t matrix_step(input req_t r);
    res_t res;
    int idx, row, last;
    int vx, vy, vz;
    logic signed [31:0] offset;
    logic signed [31:0] rows [3];
    res = '0;
    idx = int'(r.word_index);
    last = int'(WORD_LAST);
    case (r.req_type)
      REQ_LOAD: begin
        if (idx < last) begin
          mat_q[idx*2]   = r.word_data[15:0];
          mat_q[idx*2+1] = r.word_data[31:16];
        end else if (idx == last) begin
          mat_q[8] = r.word_data[15:0];
        end
      end
      REQ_ROTATE: begin
        spin_matrix(r.axis, int'($signed(r.sine)), int'($signed(r.cosine)));
      end
      REQ_MULT: begin
        vx = int'($signed(r.vec_x));
        vy = int'($signed(r.vec_y));
        vz = int'($signed(r.vec_z));
        for (row = 0; row < 3; row++) begin
          offset = (r.mult_mode == MODE_TRANS) ? trans_q[row] : '0;
          rows[row] = row_product(row, vx, vy, vz, offset);
          if (r.mult_mode != MODE_RAW) rows[row] = clamp16(rows[row]);
        end
        res.out_x = rows[0];
        res.out_y = rows[1];
        res.out_z = rows[2];
      end
      default: begin
        if (idx < last) begin
          res.read_word = {mat_q[idx*2+1], mat_q[idx*2]};
        end else if (idx == last) begin
          res.read_word = {{16{mat_q[8][15]}}, mat_q[8]};
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1: return $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
      2, 3: return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic req_t random_fields();
    req_t r;
    r.req_type   = 2'($urandom());
    r.word_index = 3'($urandom());
    r.word_data  = $urandom();
    r.axis       = 2'($urandom());
    r.sine       = rand_entry();
    r.cosine     = rand_entry();
    r.vec_x      = rand_entry();
    r.vec_y      = rand_entry();
    r.vec_z      = rand_entry();
    r.mult_mode  = 2'($urandom());
    return r;
  endfunction

  // Enter at a falling edge, leave at the falling edge after the beat is taken
  task automatic send_req(input req_t r);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= r.req_type;
    in_word_index <= r.word_index;
    in_word_data  <= r.word_data;
    in_axis       <= r.axis;
    in_sine       <= r.sine;
    in_cosine     <= r.cosine;
    in_vec_x      <= r.vec_x;
    in_vec_y      <= r.vec_y;
    in_vec_z      <= r.vec_z;
    in_mult_mode  <= r.mult_mode;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited.insert(awaited.size(), matrix_step(r));
    @(negedge clk);
  endtask

  task automatic send_load(input logic [2:0] idx, input logic [31:0] data);
    req_t r;
    r = random_fields();
    r.req_type = REQ_LOAD;
    r.word_index = idx;
    r.word_data = data;
    send_req(r);
  endtask

  task automatic send_read(input logic [2:0] idx);
    req_t r;
    r = random_fields();
    r.req_type = REQ_READ;
    r.word_index = idx;
    send_req(r);
  endtask

  task automatic send_rotate(input logic [1:0] ax, input int s, input int c);
    req_t r;
    r = random_fields();
    r.req_type = REQ_ROTATE;
    r.axis = ax;
    r.sine = s[15:0];
    r.cosine = c[15:0];
    send_req(r);
  endtask

  task automatic send_mult(input int x, input int y, input int z, input logic [1:0] mode);
    req_t r;
    r = random_fields();
    r.req_type = REQ_MULT;
    r.vec_x = x[15:0];
    r.vec_y = y[15:0];
    r.vec_z = z[15:0];
    r.mult_mode = mode;
    send_req(r);
  endtask

  // Hold the request side until every outstanding result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    trans_q[idx] = data;
    @(negedge clk);
  endtask

  task automatic set_translation(input logic [31:0] tx, input logic [31:0] ty,
                                 input logic [31:0] tz);
    wait_drained();
    write_reg(CFG_TRANS_X, tx);
    write_reg(CFG_TRANS_Y, ty);
    write_reg(CFG_TRANS_Z, tz);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_load_and_read();
    send_load(3'd0, 32'h7fff_8000);
    send_load(3'd1, 32'h8000_7fff);
    send_load(3'd2, 32'hffff_0000);
    send_load(3'd3, 32'h0001_ffff);
    // upper half of the last word is dropped
    send_load(3'd4, 32'h1234_8000);
    send_load(3'd5, 32'hdead_beef);
    for (int i = 0; i <= 4; i++) send_read(3'(i));
    send_read(3'd6);
    send_read(3'd7);
  endtask

  task automatic test_rotate_axes();
    send_rotate(AXIS_Y, -32768, 32767);
    send_rotate(AXIS_X, 2896, 2896);
    send_rotate(AXIS_Z, 32767, -32768);
    send_rotate(AXIS_NONE, 4096, 4096);
    send_read(3'd0);
  endtask

  task automatic test_multiply_modes();
    send_mult(32767, -32768, 1, MODE_SAT);
    send_mult(32767, -32768, 1, MODE_RAW);
    send_mult(-32768, -32768, -32768, MODE_SPARE);
    set_translation(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_mult(-32768, -32768, -32768, MODE_TRANS);
    send_mult(0, 0, 0, MODE_TRANS);
    send_mult(32767, 32767, 32767, MODE_RAW);
  endtask

  task automatic load_matrix();
    for (int i = 0; i <= 4; i++) send_load(3'(i), {rand_entry(), rand_entry()});
  endtask

  task automatic test_random_traffic(input int count);
    int pick, s, c;
    real ang;
    load_matrix();
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 24) == 0) load_matrix();
      if ($urandom_range(0, 149) == 0) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_req(random_fields());
      end else if (pick < 18) begin
        send_load(3'($urandom_range(0, 4)), {rand_entry(), rand_entry()});
      end else if (pick < 30) begin
        send_read(3'($urandom_range(0, 4)));
      end else if (pick < 55) begin
        if ($urandom_range(0, 9) < 7) begin
          ang = $urandom_range(0, 4095) * 6.283185307179586 / 4096.0;
          s = $rtoi(4096.0 * $sin(ang));
          c = $rtoi(4096.0 * $cos(ang));
        end else begin
          s = int'($signed(rand_entry()));
          c = int'($signed(rand_entry()));
        end
        send_rotate(2'($urandom_range(0, 2)), s, c);
      end else begin
        send_mult(int'($signed(rand_entry())), int'($signed(rand_entry())),
                  int'($signed(rand_entry())),
                  ($urandom_range(0, 9) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2)));
      end
    end
  endtask

  // Result side: random stall before each beat, with stall-free stretches
  initial begin : result_drain
    int hold;
    out_stall = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      hold = out_burst ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result beat: x=%0d y=%0d z=%0d word=%h",
                   out_x, out_y, out_z, out_read_word);
      end else begin
        want = awaited.pop_front();
        if (out_x !== want.out_x || out_y !== want.out_y || out_z !== want.out_z ||
            out_read_word !== want.read_word) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result beat wrong: expected x=%0d y=%0d z=%0d word=%h, got x=%0d y=%0d z=%0d word=%h",
                     want.out_x, want.out_y, want.out_z, want.read_word,
                     out_x, out_y, out_z, out_read_word);
        end
      end
    end
  end

  // Watchdog: cycles with no beat moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = '0;
    in_word_index = '0;
    in_word_data  = '0;
    in_axis       = '0;
    in_sine       = '0;
    in_cosine     = '0;
    in_vec_x      = '0;
    in_vec_y      = '0;
    in_vec_z      = '0;
    in_mult_mode  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    mismatches    = 0;
    idle_cycles   = 0;
    in_burst      = 1'b0;
    out_burst     = 1'b0;
    for (int i = 0; i < 9; i++) mat_q[i] = '0;
    for (int i = 0; i < 3; i++) trans_q[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_load_and_read();
    test_rotate_axes();
    test_multiply_modes();

    set_translation(32'h0, 32'h0, 32'h0);
    test_random_traffic(PHASE_ITEMS);
    set_translation(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    test_random_traffic(PHASE_ITEMS);
    set_translation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    test_random_traffic(PHASE_ITEMS);
    set_translation($urandom(), $urandom(), $urandom());
    test_random_traffic(PHASE_ITEMS);
    set_translation(32'($urandom_range(0, 65535) - 32768),
                    32'($urandom_range(0, 65535) - 32768),
                    32'($urandom_range(0, 65535) - 32768));
    test_random_traffic(PHASE_ITEMS);
    set_translation($urandom(), $urandom(), $urandom());
    test_random_traffic(PHASE_ITEMS);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
